// ===== hdl/dssq_pkg.sv =====
package dssq_pkg;

  // default queue depth and register reset
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TPS_W           = 16;
  localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

  // field widths
  localparam int THREAD_W = 8;
  localparam int DELAY_W  = 16;
  localparam int TICK_W   = 32;
  localparam int OCC_W    = 5;

  // stream widths
  localparam int S_TDATA_W = THREAD_W + DELAY_W + TICK_W;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 16;
  localparam int M_PAD_W   = M_TDATA_W - THREAD_W - OCC_W;
  localparam int M_TUSER_W = 2;

  // operation carried in s_tuser
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  // outcome of one item
  typedef enum logic [1:0] {
    RES_NONE,
    RES_ADDED,
    RES_REJECTED,
    RES_POPPED
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch input fields
    logic mul;      // register delay * rate
    logic sum;      // register deadline, pointer to tail
    logic rd;       // read entry below next pointer
    logic rd_head;  // read head entry
    logic shift;    // move read entry up one place
    logic place;    // write new entry at pointer
    logic commit;   // load result, update count and head
    res_t res;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_one;
    logic later;    // read deadline later than new deadline
    logic due;      // read deadline not later than now
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/dssq_ctrl.sv =====
module dssq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  dssq_pkg::op_t     op,
  output logic              s_tready,
  input  dssq_pkg::sts_t    sts,
  output dssq_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    MUL,
    SUM,
    SHIFT,
    PLACE,
    HEAD,
    FIN
  } state_t;

  state_t           state, state_next;
  dssq_pkg::res_t   res, res_next;

  // state and outcome registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      res   <= dssq_pkg::RES_NONE;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  assign s_tready = (state == IDLE);

  // sequencing of one item
  always_comb begin
    cmd        = '0;
    cmd.res    = res;
    state_next = state;
    res_next   = res;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (op == dssq_pkg::OP_TAKE) begin
            if (sts.empty) begin
              res_next   = dssq_pkg::RES_NONE;
              state_next = FIN;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = HEAD;
            end
          end else if (sts.full) begin
            res_next   = dssq_pkg::RES_REJECTED;
            state_next = FIN;
          end else begin
            state_next = MUL;
          end
        end
      end
      MUL: begin
        cmd.mul    = 1'b1;
        state_next = SUM;
      end
      SUM: begin
        cmd.sum = 1'b1;
        if (sts.empty) begin
          state_next = PLACE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = SHIFT;
        end
      end
      // walk down from the tail while entries are later
      SHIFT: begin
        if (sts.later) begin
          cmd.shift = 1'b1;
          if (sts.ptr_one) begin
            state_next = PLACE;
          end else begin
            cmd.rd = 1'b1;
          end
        end else begin
          cmd.place  = 1'b1;
          res_next   = dssq_pkg::RES_ADDED;
          state_next = FIN;
        end
      end
      PLACE: begin
        cmd.place  = 1'b1;
        res_next   = dssq_pkg::RES_ADDED;
        state_next = FIN;
      end
      HEAD: begin
        res_next   = sts.due ? dssq_pkg::RES_POPPED : dssq_pkg::RES_NONE;
        state_next = FIN;
      end
      FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

// ===== hdl/dssq_dp.sv =====
module dssq_dp #(
  parameter int QUEUE_DEPTH = dssq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [dssq_pkg::TPS_W-1:0]        cfg_data,
  input  logic [dssq_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dssq_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [dssq_pkg::M_TUSER_W-1:0]    m_tuser,
  input  dssq_pkg::cmd_t                    cmd,
  output dssq_pkg::sts_t                    sts
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // ring buffer position of the k-th entry from the head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] k);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) s = s - (IDX_W+1)'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  logic [dssq_pkg::TICK_W-1:0]   dl_mem [QUEUE_DEPTH];
  logic [dssq_pkg::THREAD_W-1:0] thr_mem [QUEUE_DEPTH];

  logic [dssq_pkg::TPS_W-1:0]    tps;
  logic [dssq_pkg::THREAD_W-1:0] thread_q;
  logic [dssq_pkg::DELAY_W-1:0]  delay_q;
  logic [dssq_pkg::TICK_W-1:0]   now_q;
  logic [dssq_pkg::TICK_W-1:0]   prod;
  logic [dssq_pkg::TICK_W-1:0]   deadline;
  logic [dssq_pkg::TICK_W-1:0]   rd_dl;
  logic [dssq_pkg::THREAD_W-1:0] rd_thr;
  logic [CNT_W-1:0]              count, count_next;
  logic [IDX_W-1:0]              head;
  logic [CNT_W-1:0]              ptr, ptr_next, ptr_rd;
  logic [IDX_W-1:0]              rd_addr, wr_addr;
  logic [dssq_pkg::TICK_W-1:0]   wr_dl;
  logic [dssq_pkg::THREAD_W-1:0] wr_thr;
  logic                          wr_en;
  logic                          popped, rejected;

  // rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= dssq_pkg::TPS_RESET;
    end else if (cfg_valid) begin
      tps <= cfg_data;
    end
  end

  // input fields, product and deadline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      thread_q <= s_tdata[dssq_pkg::THREAD_W-1:0];
      delay_q  <= s_tdata[dssq_pkg::THREAD_W +: dssq_pkg::DELAY_W];
      now_q    <= s_tdata[dssq_pkg::THREAD_W + dssq_pkg::DELAY_W +: dssq_pkg::TICK_W];
    end
    if (cmd.mul) begin
      prod <= dssq_pkg::TICK_W'(delay_q) * dssq_pkg::TICK_W'(tps);
    end
    if (cmd.sum) begin
      deadline <= now_q + prod;
    end
  end

  // insertion pointer, counted from the head
  always_comb begin
    priority if (cmd.sum) begin
      ptr_next = count;
    end else if (cmd.shift) begin
      ptr_next = ptr - CNT_W'(1);
    end else begin
      ptr_next = ptr;
    end
  end

  assign ptr_rd  = ptr_next - CNT_W'(1);
  assign rd_addr = cmd.rd_head ? head : phys(head, ptr_rd[IDX_W-1:0]);
  assign wr_addr = phys(head, ptr[IDX_W-1:0]);
  assign wr_en   = cmd.shift | cmd.place;
  assign wr_dl   = cmd.shift ? rd_dl : deadline;
  assign wr_thr  = cmd.shift ? rd_thr : thread_q;

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
  end

  // queue memories, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_mem[wr_addr]  <= wr_dl;
      thr_mem[wr_addr] <= wr_thr;
    end
    if (cmd.rd | cmd.rd_head) begin
      rd_dl  <= dl_mem[rd_addr];
      rd_thr <= thr_mem[rd_addr];
    end
  end

  // count after this item
  assign popped   = (cmd.res == dssq_pkg::RES_POPPED);
  assign rejected = (cmd.res == dssq_pkg::RES_REJECTED);

  always_comb begin
    unique case (cmd.res)
      dssq_pkg::RES_ADDED:  count_next = count + CNT_W'(1);
      dssq_pkg::RES_POPPED: count_next = count - CNT_W'(1);
      default:              count_next = count;
    endcase
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
      if (popped) head <= phys(head, IDX_W'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{dssq_pkg::M_PAD_W{1'b0}},
                  dssq_pkg::OCC_W'(count_next),
                  popped ? rd_thr : {dssq_pkg::THREAD_W{1'b0}}};
      m_tuser <= {rejected, popped};
    end
  end

  // status
  assign sts.full     = (count == CNT_W'(QUEUE_DEPTH));
  assign sts.empty    = (count == '0);
  assign sts.ptr_one  = (ptr == CNT_W'(1));
  assign sts.later    = (rd_dl > deadline);
  assign sts.due      = (rd_dl <= now_q);
  assign sts.out_free = ~m_tvalid | m_tready;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_add_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd.res == dssq_pkg::RES_ADDED |-> !sts.full)
    else $error("insertion committed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && popped |-> !sts.empty)
    else $error("pop committed from an empty queue");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

endmodule

// ===== hdl/deadline_sorted_sleep_queue.sv =====
// Sleep queue of up to QUEUE_DEPTH thread ids kept in deadline order in a ring
// buffer memory. Each beat on the slave side gives exactly one result beat on
// the master side, once the result register can take it. A take checks the
// head against now_ticks and pops it if due. An add walks down from the tail
// past every queued entry whose deadline is later than the new one (at most
// QUEUE_DEPTH - 1), moving each up one place through the one read port and
// the one write port of the queue memory; a full queue rejects the add.
// Deadlines wrap modulo 2^32 and are compared unsigned. The ticks_per_second
// register is written through the cfg channel, is always ready, and should
// only change while the block is idle.
module deadline_sorted_sleep_queue #(
  parameter int QUEUE_DEPTH = dssq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: ticks_per_second
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dssq_pkg::TPS_W-1:0]        cfg_data,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dssq_pkg::S_TDATA_W-1:0]    s_tdata,  // thread_id, delay_seconds, now_ticks
  input  logic [dssq_pkg::S_TUSER_W-1:0]    s_tuser,  // operation
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dssq_pkg::M_TDATA_W-1:0]    m_tdata,  // woken_thread, occupancy, zero pad
  output logic [dssq_pkg::M_TUSER_W-1:0]    m_tuser   // woken_valid, add_rejected
);

  dssq_pkg::cmd_t cmd;
  dssq_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dssq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (dssq_pkg::op_t'(s_tuser[0])),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dssq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== tb/sv/deadline_sorted_sleep_queue_tb.sv =====
`timescale 1ns / 100ps

module deadline_sorted_sleep_queue_tb;

  localparam int QD          = dssq_pkg::QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCH_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  // one expected result beat
  typedef struct packed {
    logic                          woken;
    logic [dssq_pkg::THREAD_W-1:0] thread;
    logic                          rejected;
    logic [dssq_pkg::OCC_W-1:0]    occ;
  } outcome_t;

  logic                           clk;
  logic                           rst       = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dssq_pkg::TPS_W-1:0]     cfg_data  = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [dssq_pkg::S_TDATA_W-1:0] s_tdata   = '0;  // thread_id, delay_seconds, now_ticks
  logic [dssq_pkg::S_TUSER_W-1:0] s_tuser   = '0;  // operation
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [dssq_pkg::M_TDATA_W-1:0] m_tdata;         // woken_thread, occupancy, zero pad
  logic [dssq_pkg::M_TUSER_W-1:0] m_tuser;         // woken_valid, add_rejected

  // predicted queue contents, head at index 0
  logic [dssq_pkg::TICK_W-1:0]   sleep_deadline [QD];
  logic [dssq_pkg::THREAD_W-1:0] sleep_thread   [QD];
  int                            depth_used = 0;
  logic [dssq_pkg::TPS_W-1:0]    rate       = dssq_pkg::TPS_RESET;

  outcome_t outcomes_due[$];
  outcome_t want;
  int       mismatches  = 0;
  bit       idle_en     = 1'b1;
  bit       hold_req    = 1'b0;
  int       hold_left   = 0;
  int       rx_stall    = 0;
  int       idle_cycles = 0;

  deadline_sorted_sleep_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sorted insert on add, pop of a due head on take
  function automatic outcome_t predict_outcome(dssq_pkg::op_t op,
                                               logic [dssq_pkg::THREAD_W-1:0] tid,
                                               logic [dssq_pkg::DELAY_W-1:0] dly,
                                               logic [dssq_pkg::TICK_W-1:0] now);
    outcome_t                    r;
    logic [dssq_pkg::TICK_W-1:0] dl;
    int                          pos;
    r = '0;
    if (op == dssq_pkg::OP_ADD) begin
      dl = now + dssq_pkg::TICK_W'(dly) * dssq_pkg::TICK_W'(rate);
      if (depth_used >= QD) begin
        r.rejected = 1'b1;
      end else begin
        pos = 0;
        while (pos < depth_used && sleep_deadline[pos] <= dl) pos++;
        for (int i = depth_used; i > pos; i--) begin
          sleep_deadline[i] = sleep_deadline[i-1];
          sleep_thread[i]   = sleep_thread[i-1];
        end
        sleep_deadline[pos] = dl;
        sleep_thread[pos]   = tid;
        depth_used++;
      end
    end else if (depth_used != 0 && sleep_deadline[0] <= now) begin
      r.woken  = 1'b1;
      r.thread = sleep_thread[0];
      for (int i = 1; i < depth_used; i++) begin
        sleep_deadline[i-1] = sleep_deadline[i];
        sleep_thread[i-1]   = sleep_thread[i];
      end
      depth_used--;
    end
    r.occ = dssq_pkg::OCC_W'(depth_used);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, exp_v, $realtime);
    mismatches++;
  endtask

  // offer one item, optionally after a random gap, and predict it on acceptance
  task automatic send_item(dssq_pkg::op_t op, logic [dssq_pkg::THREAD_W-1:0] tid,
                           logic [dssq_pkg::DELAY_W-1:0] dly,
                           logic [dssq_pkg::TICK_W-1:0] now);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now, dly, tid};
    do @(posedge clk); while (!s_tready);
    outcomes_due.push_back(predict_outcome(op, tid, dly, now));
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle_queue();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_rate(logic [dssq_pkg::TPS_W-1:0] v);
    settle_queue();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    rate = v;
    cfg_valid <= 1'b0;
  endtask

  // empty queue, equal deadlines, head not yet due, deadline wrap
  task automatic test_due_and_ties();
    send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'd0);
    send_item(dssq_pkg::OP_ADD, 8'h00, 16'd0, 32'd0);
    send_item(dssq_pkg::OP_ADD, 8'hA5, 16'd0, 32'd0);
    send_item(dssq_pkg::OP_ADD, 8'h5A, 16'd5, 32'd100);
    send_item(dssq_pkg::OP_ADD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'd0);
    send_item(dssq_pkg::OP_TAKE, 8'hFF, 16'hFFFF, 32'd0);
    send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'd50);
    send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'd5100);
    send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'd65534998);
    send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'd65534999);
    send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'hFFFF_FFFF);
    settle_queue();
  endtask

  // fill to the brim, adds past it are rejected, then drain past empty
  task automatic test_full_queue();
    while (depth_used < QD)
      send_item(dssq_pkg::OP_ADD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 20)),
                $urandom);
    send_item(dssq_pkg::OP_ADD, 8'h12, 16'd0, 32'd0);
    send_item(dssq_pkg::OP_ADD, 8'h34, 16'hFFFF, 32'hFFFF_FFFF);
    while (depth_used > 0)
      send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'hFFFF_FFFF);
    send_item(dssq_pkg::OP_TAKE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    settle_queue();
  endtask

  // slowest and fastest tick rates, and a zero rate
  task automatic test_rate_extremes();
    logic [dssq_pkg::TPS_W-1:0] rates [3];
    rates = '{16'd1, 16'hFFFF, 16'd0};
    foreach (rates[k]) begin
      write_rate(rates[k]);
      send_item(dssq_pkg::OP_ADD, 8'($urandom_range(0, 255)), 16'hFFFF, $urandom);
      send_item(dssq_pkg::OP_ADD, 8'($urandom_range(0, 255)), 16'd1, 32'd7);
      send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'd7);
      send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'hFFFF_FFFF);
      send_item(dssq_pkg::OP_TAKE, 8'h00, 16'h0000, 32'hFFFF_FFFF);
    end
    write_rate(dssq_pkg::TPS_RESET);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_stall();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    repeat (24)
      send_item(dssq_pkg::op_t'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 9)), $urandom_range(0, 20000));
    settle_queue();
    idle_en = 1'b1;
  endtask

  // a moving tick with short sleeps, mixed with fully random beats
  task automatic test_random_traffic(int n_items, logic [dssq_pkg::TPS_W-1:0] r, bit idling);
    logic [dssq_pkg::TICK_W-1:0] tick;
    int                          take_pct;
    dssq_pkg::op_t               op;
    write_rate(r);
    idle_en = idling;
    tick    = $urandom;
    repeat (n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(dssq_pkg::op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), $urandom);
      end else if ($urandom_range(0, 19) == 0) begin
        send_item(dssq_pkg::OP_TAKE, 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 32'hFFFF_FFFF);
      end else begin
        take_pct = (depth_used >= QD - 2) ? 70 : (depth_used < 3) ? 25 : 50;
        op       = ($urandom_range(0, 99) < take_pct) ? dssq_pkg::OP_TAKE : dssq_pkg::OP_ADD;
        tick     = tick + $urandom_range(0, 3 * r + 3);
        send_item(op, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 4)), tick);
      end
    end
    settle_queue();
  endtask

  // receiver with random stall bursts and a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      rx_stall = $urandom_range(1, 17) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result beat with nothing expected", {m_tuser, m_tdata}, 0);
      end else begin
        want = outcomes_due.pop_front();
        if (m_tuser[0] !== want.woken)
          report_mismatch("woken_valid", m_tuser[0], want.woken);
        if (m_tdata[dssq_pkg::THREAD_W-1:0] !== want.thread)
          report_mismatch("woken_thread", m_tdata[dssq_pkg::THREAD_W-1:0], want.thread);
        if (m_tuser[1] !== want.rejected)
          report_mismatch("add_rejected", m_tuser[1], want.rejected);
        if (m_tdata[dssq_pkg::THREAD_W +: dssq_pkg::OCC_W] !== want.occ)
          report_mismatch("occupancy", m_tdata[dssq_pkg::THREAD_W +: dssq_pkg::OCC_W],
                          want.occ);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    while (idle_cycles < WATCH_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("deadline_sorted_sleep_queue verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_due_and_ties();
    test_full_queue();
    test_rate_extremes();
    test_output_stall();
    test_random_traffic(90, 16'd1, 1'b1);
    test_random_traffic(90, 16'hFFFF, 1'b1);
    test_random_traffic(90, 16'($urandom_range(2, 65534)), 1'b1);
    test_random_traffic(90, dssq_pkg::TPS_RESET, 1'b1);
    test_random_traffic(90, 16'($urandom_range(1, 65535)), 1'b0);
    settle_queue();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outcomes_due.size() != 0)
      report_mismatch("results still expected at end", 0, outcomes_due.size());
    if (mismatches == 0)
      $display("deadline_sorted_sleep_queue verification clean");
    else
      $display("deadline_sorted_sleep_queue verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dssq_pkg.sv
hdl/dssq_ctrl.sv
hdl/dssq_dp.sv
hdl/deadline_sorted_sleep_queue.sv
tb/sv/deadline_sorted_sleep_queue_tb.sv
